// ----- rtl/olh_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olh_pkg
// Shared types and constants for the OLH support counter block.
// ----------------------------------------------------------------------------
package olh_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int ITEM_W     = $clog2(MAX_ITEMS);
    localparam int COUNT_W    = 32;
    localparam int HASH_W     = 30;
    localparam int PROD_W     = 42;

    localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1000000007;

    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  reported_value;
        logic [29:0] hash_mult;
        logic [29:0] hash_add;
        logic [15:0] uniform_sample;
        logic [9:0]  read_index;
    } t_req;

    typedef struct packed {
        logic [7:0]  chosen_bucket;
        logic [10:0] supported_items;
        logic [31:0] count_value;
    } t_rsp;

endpackage
`default_nettype wire

// ----- rtl/olh_mod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olh_mod
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module olh_mod (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [olh_pkg::PROD_W-1:0]    i_dividend,
    input  wire [olh_pkg::HASH_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [olh_pkg::HASH_W-1:0]   o_rem
);
    import olh_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [PROD_W-1:0] r_num;
    logic [HASH_W-1:0] r_den;
    logic [HASH_W-1:0] r_rem;
    logic [HASH_W:0]   w_trial;
    logic [HASH_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_num[PROD_W-1]};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = HASH_W'(w_trial - {1'b0, r_den});
        end else begin
            n_rem = w_trial[HASH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[PROD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

// ----- rtl/olh_report_support_counter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olh_report_support_counter_top
// Optimised local hashing aggregator with a 1024 x 32 support counter RAM.
// ----------------------------------------------------------------------------
// Input channel i_in / i_in_valid / o_in_stall carries one request item; the
// item is taken when valid is high and stall is low. One item is worked on
// at a time; o_in_stall is high from acceptance until the block is idle.
// A read item reads the counter RAM in S_RD, captures the count in S_RD2
// and passes it to the output register in S_FIN. A report item forms the
// 41-bit hash product in S_MUL and S_ADD, folds it modulo the prime in
// S_D1, runs four passes of the bit-serial remainder unit to derive the
// true bucket and the per-item hash steps, walks the randomised response,
// then sweeps the counter RAM one item per cycle (n = num_items, capped at
// 1024), read-modify-write through a registered read. With g zero the
// product state passes straight to the output state.
// Results go to an output register (o_out / o_out_valid, receiver stall
// i_out_stall); a new item is taken while a result still waits, and the
// block holds its last result until the receiver takes it.
// After reset the 1024-word counter RAM is cleared, during which no
// item is taken; APB register writes are taken at all times.
// ----------------------------------------------------------------------------
module olh_report_support_counter_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  wire  olh_pkg::t_req i_in,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    output olh_pkg::t_rsp       o_out,
    output logic                o_out_valid,
    input  wire                 i_out_stall
);
    import olh_pkg::*;

    localparam logic [1:0] REG_NUM   = 2'd0;
    localparam logic [1:0] REG_G     = 2'd1;
    localparam logic [1:0] REG_KEEP  = 2'd2;
    localparam logic [1:0] REG_OTHER = 2'd3;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ADD   = 4'd3;
    localparam logic [3:0] S_D1    = 4'd4;
    localparam logic [3:0] S_D2    = 4'd5;
    localparam logic [3:0] S_D3    = 4'd6;
    localparam logic [3:0] S_D4    = 4'd7;
    localparam logic [3:0] S_D5    = 4'd8;
    localparam logic [3:0] S_WALK  = 4'd9;
    localparam logic [3:0] S_SWEEP = 4'd10;
    localparam logic [3:0] S_DRAIN = 4'd11;
    localparam logic [3:0] S_RD    = 4'd12;
    localparam logic [3:0] S_RD2   = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    localparam int XW = ITEM_W + 1;
    localparam logic [XW-1:0] N_MAX = XW'(MAX_ITEMS);

    // 2^30 mod the prime
    localparam logic [HASH_W-1:0] FOLD_C = 30'd73741817;

    // configuration
    logic [10:0] r_num_items;
    logic [7:0]  r_g;
    logic [15:0] r_keep;
    logic [15:0] r_other;
    logic        w_cfg_wr;

    // sequencer
    logic [3:0]        r_state;
    t_req              r_req;
    logic [XW-1:0]     r_x;
    logic [PROD_W-1:0] r_prod;
    logic [HASH_W-1:0] r_hv;
    logic [HASH_W-1:0] r_am_p;
    logic [HASH_W-1:0] r_h;
    logic [7:0]        r_truth;
    logic [7:0]        r_amg;
    logic [7:0]        r_pmg;
    logic [7:0]        r_r;
    logic [7:0]        r_y;
    logic signed [17:0] r_frac;
    logic [10:0]       r_hits;
    logic              r_div_run;
    t_rsp              r_res;
    t_rsp              r_out;
    logic              r_out_valid;

    // sweep pipeline
    logic              r_p_valid;
    logic              r_p_hit;
    logic [ITEM_W-1:0] r_p_addr;

    // counter RAM
    logic [COUNT_W-1:0] mem [MAX_ITEMS];
    logic [COUNT_W-1:0] r_rdata;
    logic               mem_we;
    logic [ITEM_W-1:0]  mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ITEM_W-1:0]  mem_raddr;

    // divider
    logic              div_start;
    logic [PROD_W-1:0] div_num;
    logic [HASH_W-1:0] div_den;
    logic              div_done;
    logic [HASH_W-1:0] div_rem;

    // datapath
    logic [XW-1:0]     w_n;
    logic [HASH_W-1:0] w_a_m;
    logic [HASH_W-1:0] w_b_m;
    logic [HASH_W:0]   w_ab;
    logic [HASH_W-1:0] w_h0;
    logic [PROD_W-1:0] w_fold;
    logic [HASH_W-1:0] w_lo;
    logic [HASH_W:0]   w_s;
    logic              w_wrap;
    logic [HASH_W-1:0] n_h;
    logic signed [9:0] w_t;
    logic [7:0]        n_r;
    logic signed [17:0] n_frac;
    logic              w_is_div;
    logic              w_out_free;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_items <= 11'd1024;
            r_g         <= 8'd4;
            r_keep      <= 16'd31150;
            r_other     <= 16'd11462;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_NUM:   r_num_items <= pwdata[10:0];
                REG_G:     r_g         <= pwdata[7:0];
                REG_KEEP:  r_keep      <= pwdata[15:0];
                REG_OTHER: r_other     <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_NUM:   prdata = {21'd0, r_num_items};
            REG_G:     prdata = {24'd0, r_g};
            REG_KEEP:  prdata = {16'd0, r_keep};
            REG_OTHER: prdata = {16'd0, r_other};
            default:   prdata = '0;
        endcase
    end

    // ---------------- divider ----------------
    olh_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign w_is_div  = (r_state == S_D2) || (r_state == S_D3) ||
                       (r_state == S_D4) || (r_state == S_D5);
    assign div_start = w_is_div && !r_div_run;

    always_comb begin
        div_den = {22'd0, r_g};
        case (r_state)
            S_D2:    div_num = {12'd0, r_hv};
            S_D3:    div_num = {12'd0, r_am_p};
            S_D4:    div_num = {12'd0, HASH_PRIME};
            S_D5:    div_num = {12'd0, r_h};
            default: div_num = r_prod;
        endcase
    end

    // ---------------- hash arithmetic ----------------
    assign w_n   = (r_num_items > N_MAX) ? N_MAX : r_num_items;
    assign w_a_m = (r_req.hash_mult >= HASH_PRIME) ? r_req.hash_mult - HASH_PRIME
                                                  : r_req.hash_mult;
    assign w_b_m = (r_req.hash_add >= HASH_PRIME) ? r_req.hash_add - HASH_PRIME
                                                 : r_req.hash_add;
    assign w_ab  = {1'b0, w_a_m} + {1'b0, w_b_m};
    assign w_h0  = (w_ab >= {1'b0, HASH_PRIME}) ? HASH_W'(w_ab - {1'b0, HASH_PRIME})
                                               : w_ab[HASH_W-1:0];

    // fold the bits above bit 29 back in, weighted by 2^30 mod the prime
    assign w_fold = PROD_W'(r_prod[PROD_W-1:HASH_W]) * PROD_W'(FOLD_C) +
                    PROD_W'(r_prod[HASH_W-1:0]);
    assign w_lo   = r_prod[HASH_W-1:0];

    // step the hash of item x to item x+1, tracking its residue mod g
    assign w_s    = {1'b0, r_h} + {1'b0, r_am_p};
    assign w_wrap = (w_s >= {1'b0, HASH_PRIME});
    assign n_h    = w_wrap ? HASH_W'(w_s - {1'b0, HASH_PRIME}) : w_s[HASH_W-1:0];

    always_comb begin
        w_t = $signed({2'b00, r_r}) + $signed({2'b00, r_amg});
        if (w_wrap) begin
            w_t = w_t - $signed({2'b00, r_pmg});
        end
        if (w_t < 0) begin
            n_r = 8'(w_t + $signed({2'b00, r_g}));
        end else if (w_t >= $signed({2'b00, r_g})) begin
            n_r = 8'(w_t - $signed({2'b00, r_g}));
        end else begin
            n_r = w_t[7:0];
        end
    end

    assign n_frac = r_frac - $signed({2'b00, (r_y == r_truth) ? r_keep : r_other});

    // ---------------- memory port control ----------------
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_p_addr;
        mem_wdata = (r_rdata == {COUNT_W{1'b1}}) ? r_rdata : r_rdata + 1'b1;
        mem_re    = 1'b0;
        mem_raddr = r_x[ITEM_W-1:0];
        if (r_state == S_CLR) begin
            mem_we    = 1'b1;
            mem_waddr = r_x[ITEM_W-1:0];
            mem_wdata = '0;
        end else if (r_p_valid && r_p_hit) begin
            mem_we = 1'b1;
        end
        if (r_state == S_SWEEP) begin
            mem_re = 1'b1;
        end else if (r_state == S_RD) begin
            mem_re    = 1'b1;
            mem_raddr = r_req.read_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // ---------------- sequencer ----------------
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_x         <= '0;
            r_div_run   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p_valid <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (div_start) begin
                r_div_run <= 1'b1;
            end
            if (div_done) begin
                r_div_run <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_x <= r_x + 1'b1;
                    if (r_x[ITEM_W-1:0] == {ITEM_W{1'b1}}) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req <= i_in;
                        r_res <= '0;
                        r_state <= (i_in.req_type == REQ_READ) ? S_RD : S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= PROD_W'(11'(r_req.reported_value) + 11'd1) *
                              PROD_W'(r_req.hash_mult);
                    r_am_p <= w_a_m;
                    r_h    <= w_h0;
                    r_state <= (r_g == 8'd0) ? S_FIN : S_ADD;
                end
                S_ADD: begin
                    r_prod  <= r_prod + PROD_W'(r_req.hash_add);
                    r_state <= S_D1;
                end
                S_D1: begin
                    if (r_prod[PROD_W-1:HASH_W] != '0) begin
                        r_prod <= w_fold;
                    end else begin
                        r_hv    <= (w_lo >= HASH_PRIME) ? HASH_W'(w_lo - HASH_PRIME) : w_lo;
                        r_state <= S_D2;
                    end
                end
                S_D2: if (div_done) begin
                    r_truth <= div_rem[7:0];
                    r_state <= S_D3;
                end
                S_D3: if (div_done) begin
                    r_amg   <= div_rem[7:0];
                    r_state <= S_D4;
                end
                S_D4: if (div_done) begin
                    r_pmg   <= div_rem[7:0];
                    r_state <= S_D5;
                end
                S_D5: if (div_done) begin
                    r_r     <= div_rem[7:0];
                    r_y     <= '0;
                    r_frac  <= $signed({2'b00, r_req.uniform_sample});
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_frac <= n_frac;
                    if (n_frac < 0) begin
                        r_res.chosen_bucket <= r_y;
                        r_x    <= '0;
                        r_hits <= '0;
                        r_state <= (w_n == '0) ? S_FIN : S_SWEEP;
                    end else if (r_y + 1'b1 == r_g) begin
                        // walk ran out: bucket g matches no hash
                        r_res.chosen_bucket <= r_g;
                        r_state <= S_FIN;
                    end else begin
                        r_y <= r_y + 1'b1;
                    end
                end
                S_SWEEP: begin
                    r_p_valid <= 1'b1;
                    r_p_hit   <= (r_r == r_res.chosen_bucket);
                    r_p_addr  <= r_x[ITEM_W-1:0];
                    if (r_r == r_res.chosen_bucket) begin
                        r_hits <= r_hits + 1'b1;
                    end
                    r_h <= n_h;
                    r_r <= n_r;
                    r_x <= r_x + 1'b1;
                    if (r_x == w_n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_res.supported_items <= r_hits;
                    r_state <= S_FIN;
                end
                S_RD: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_res.count_value <= r_rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ----- rtl/olh_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// olh_chk
// Port-level checks for the OLH support counter block.
// ----------------------------------------------------------------------------
module olh_chk (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire olh_pkg::t_req i_in,
    input wire                i_in_valid,
    input wire                o_in_stall,
    input wire olh_pkg::t_rsp o_out,
    input wire                o_out_valid,
    input wire                i_out_stall
);
    import olh_pkg::*;

    // clearing pass blocks input right after reset
    a_clear_stall: assert property (@(posedge i_clk) !i_rst_n |=> o_in_stall)
        else $error("input taken during counter clear");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result dropped or changed");

    // reports never carry a counter value
    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.chosen_bucket != 8'd0 || o_out.supported_items != 11'd0)
        |-> o_out.count_value == 32'd0)
        else $error("report result carries a counter value");

endmodule

bind olh_report_support_counter_top olh_chk u_olh_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in        (i_in),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out       (o_out),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);
`default_nettype wire

// ----- dv/olh_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olh_tb_pkg
// Register map of the OLH support counter block as seen by the testbench.
// ----------------------------------------------------------------------------
package olh_tb_pkg;

    localparam logic [3:0] ADDR_NUM_ITEMS    = 4'd0;
    localparam logic [3:0] ADDR_BUCKET_COUNT = 4'd4;
    localparam logic [3:0] ADDR_KEEP_PROB    = 4'd8;
    localparam logic [3:0] ADDR_OTHER_PROB   = 4'd12;

    localparam longint unsigned HASH_MOD = 64'd1000000007;

endpackage

// ----- dv/olh_report_support_counter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olh_report_support_counter_checker
// Watches the register port and both item channels, keeps its own copy of
// the support counters and registers, and compares every result item with
// the oldest predicted one. Hands the failure count to the test top.
// ----------------------------------------------------------------------------
module olh_report_support_counter_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [3:0]          paddr,
    input  wire  [31:0]         pwdata,
    input  wire                 pready,
    input  wire  olh_pkg::t_req i_in,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  wire  olh_pkg::t_rsp i_out,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    output int                  o_fail_count
);
    import olh_pkg::*;
    import olh_tb_pkg::*;

    logic [31:0] support_model [MAX_ITEMS];
    logic [10:0] num_items_q;
    logic [7:0]  bucket_count_q;
    logic [15:0] keep_prob_q;
    logic [15:0] other_prob_q;
    t_rsp        expected_rsps [$];
    int          mismatches;

    assign o_fail_count = mismatches + expected_rsps.size();

    function automatic int unsigned bucket_of(longint unsigned x, longint unsigned a,
                                              longint unsigned b, int unsigned g);
        longint unsigned h;
        h = ((x + 1) * a + b) % HASH_MOD;
        return int'(h % g);
    endfunction

    // Update the counter copy and return the result item for one request.
    function automatic t_rsp apply_request(t_req r);
        t_rsp        rsp;
        longint      frac;
        int unsigned g, y, n, hits, truth, x;
        rsp  = '0;
        if (r.req_type == REQ_READ) begin
            rsp.count_value = support_model[r.read_index];
            return rsp;
        end
        g    = bucket_count_q;
        n    = (num_items_q > MAX_ITEMS) ? MAX_ITEMS : num_items_q;
        y    = 0;
        hits = 0;
        frac = r.uniform_sample;
        if (g != 0) begin
            truth = bucket_of(r.reported_value, r.hash_mult, r.hash_add, g);
            for (y = 0; y < g; y++) begin
                frac -= (y == truth) ? keep_prob_q : other_prob_q;
                if (frac < 0) break;
            end
            if (y < g) begin
                for (x = 0; x < n; x++) begin
                    if (bucket_of(x, r.hash_mult, r.hash_add, g) == y) begin
                        if (support_model[x] != 32'hFFFF_FFFF)
                            support_model[x] += 1;
                        hits++;
                    end
                end
            end
        end
        rsp.chosen_bucket   = y[7:0];
        rsp.supported_items = hits[10:0];
        return rsp;
    endfunction

    initial begin
        foreach (support_model[k]) support_model[k] = '0;
        num_items_q    = 11'd1024;
        bucket_count_q = 8'd4;
        keep_prob_q    = 16'd31150;
        other_prob_q   = 16'd11462;
        mismatches     = 0;
    end

    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_NUM_ITEMS:    num_items_q    = pwdata[10:0];
                    ADDR_BUCKET_COUNT: bucket_count_q = pwdata[7:0];
                    ADDR_KEEP_PROB:    keep_prob_q    = pwdata[15:0];
                    ADDR_OTHER_PROB:   other_prob_q   = pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_rsps.push_back(apply_request(i_in));
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, i_out);
                    mismatches++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (i_out.chosen_bucket !== exp_rsp.chosen_bucket) begin
                        $display("%0t: chosen_bucket expected %0d actual %0d", $time,
                                 exp_rsp.chosen_bucket, i_out.chosen_bucket);
                        mismatches++;
                    end
                    if (i_out.supported_items !== exp_rsp.supported_items) begin
                        $display("%0t: supported_items expected %0d actual %0d", $time,
                                 exp_rsp.supported_items, i_out.supported_items);
                        mismatches++;
                    end
                    if (i_out.count_value !== exp_rsp.count_value) begin
                        $display("%0t: count_value expected %0d actual %0d", $time,
                                 exp_rsp.count_value, i_out.count_value);
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// ----- dv/olh_report_support_counter_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olh_report_support_counter_top_test
// Drives report and read items through the OLH support counter block over
// several register settings, with random gaps and receiver stalls; the
// checker predicts every result item and counts mismatches.
// ----------------------------------------------------------------------------
module olh_report_support_counter_top_test;
    import olh_pkg::*;
    import olh_tb_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int PHASE_ITEMS = 85;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    t_req        i_in = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_rsp        o_out;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    int          fail_count;
    int          items_sent = 0;
    int          items_back = 0;
    int          cycles = 0;
    bit          no_idle = 1'b0;

    olh_report_support_counter_top i_dut (.*);

    olh_report_support_counter_checker i_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_in, .i_in_valid, .i_in_stall(o_in_stall),
        .i_out(o_out), .i_out_valid(o_out_valid), .i_out_stall,
        .o_fail_count(fail_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("olh_report_support_counter_top: mismatch");
            $finish;
        end
        i_out_stall <= !no_idle && ($urandom_range(0, 99) < 10);
        if (o_out_valid && !i_out_stall) items_back <= items_back + 1;
    end

    task automatic reg_write(logic [3:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain outstanding results, then rewrite all four registers.
    task automatic set_regs(int n, int g, int keep, int other);
        while (items_back != items_sent) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        reg_write(ADDR_NUM_ITEMS, n);
        reg_write(ADDR_BUCKET_COUNT, g);
        reg_write(ADDR_KEEP_PROB, keep);
        reg_write(ADDR_OTHER_PROB, other);
    endtask

    task automatic send(t_req r);
        if (!no_idle && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in       <= r;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic t_req random_req(bit is_read);
        t_req r;
        r.req_type       = is_read ? REQ_READ : REQ_REPORT;
        r.reported_value = $urandom();
        r.hash_mult      = $urandom();
        r.hash_add       = $urandom();
        r.uniform_sample = $urandom();
        r.read_index     = $urandom();
        return r;
    endfunction

    task automatic send_report(int v, int a, int b, int u);
        t_req r;
        r                = random_req(1'b0);
        r.reported_value = v;
        r.hash_mult      = a;
        r.hash_add       = b;
        r.uniform_sample = u;
        send(r);
    endtask

    task automatic send_read(int idx);
        t_req r;
        r            = random_req(1'b1);
        r.read_index = idx;
        send(r);
    endtask

    task automatic random_phase(int count);
        repeat (count) send(random_req($urandom_range(0, 99) < 30));
        i_in_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults, field extremes, hash wrap, empty walk
        set_regs(1024, 4, 31150, 11462);
        send_read(0);
        send_read(1023);
        send_report(0, 0, 0, 0);
        send_report(1023, 1000000006, 1000000006, 65535);
        send_report(1023, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 40000);
        send_report(5, 1, 0, 31149);
        send_report(5, 1, 0, 31150);
        send_read(0);
        send_read(1023);
        i_in_valid <= 1'b0;
        set_regs(16, 2, 0, 0);
        send_report(3, 12345, 678, 0);
        send_report(3, 12345, 678, 65535);
        i_in_valid <= 1'b0;
        set_regs(2047, 255, 65535, 65535);
        send_report(7, 999, 1, 0);
        send_report(7, 999, 1, 65535);
        i_in_valid <= 1'b0;
        set_regs(0, 0, 1, 1);
        send_report(1, 2, 3, 65535);
        send_read(5);
        i_in_valid <= 1'b0;

        // random phases across settings
        set_regs(1024, 4, 31150, 11462);
        random_phase(PHASE_ITEMS);
        set_regs(16, 2, 65535, 0);
        no_idle = 1'b1;
        random_phase(PHASE_ITEMS);
        no_idle = 1'b0;
        set_regs(2047, 255, 200, 100);
        random_phase(PHASE_ITEMS);
        set_regs(1, 0, 0, 0);
        random_phase(40);
        set_regs(64, 255, 0, 65535);
        random_phase(PHASE_ITEMS);
        set_regs($urandom_range(2, 200), $urandom_range(2, 16), $urandom_range(0, 65535),
                 $urandom_range(0, 8000));
        random_phase(PHASE_ITEMS);
        set_regs(1000, 3, 32768, 16384);
        random_phase(60);

        while (items_back != items_sent) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("olh_report_support_counter_top: match");
        else
            $display("olh_report_support_counter_top: mismatch");
        $finish;
    end

endmodule
